// ----- rtl/core/string_rotation_match_macros.svh -----
// assertion helpers shared by the rtl files
`ifndef STRING_ROTATION_MATCH_MACROS_SVH
`define STRING_ROTATION_MATCH_MACROS_SVH

// condition must hold in the same cycle as the trigger
`define SRM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition must hold in the cycle after the trigger
`define SRM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/srm_pkg.sv -----
package srm_pkg;

	// default longest string the stores hold
	localparam int MAX_LEN_DEF = 128;

	localparam int CHAR_W = 8;
	localparam int ROT_W  = 7;
	localparam int STAT_W = 2;

	// result status codes
	localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NO_MATCH = 2'd1;
	localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd2;

	// character pair written into the stores
	typedef struct packed {
		logic              en;
		logic [CHAR_W-1:0] src_char;
		logic [CHAR_W-1:0] dst_char;
	} wr_t;

	// finished result handed from the sequencer to the output register
	typedef struct packed {
		logic              valid;
		logic [ROT_W-1:0]  rotations;
		logic [STAT_W-1:0] status;
	} res_t;

endpackage

// ----- rtl/core/srm_channels.sv -----
// character pair channel
interface srm_char_if;
	logic                      valid;
	logic                      ready;
	logic [srm_pkg::CHAR_W-1:0] src_char;
	logic [srm_pkg::CHAR_W-1:0] dst_char;
	logic                      last;

	modport source (output valid, output src_char, output dst_char, output last, input ready);
	modport sink (input valid, input src_char, input dst_char, input last, output ready);
endinterface

// result channel
interface srm_res_if;
	logic                      valid;
	logic                      ready;
	logic [srm_pkg::ROT_W-1:0]  rotations;
	logic [srm_pkg::STAT_W-1:0] status;

	modport source (output valid, output rotations, output status, input ready);
	modport sink (input valid, input rotations, input status, output ready);
endinterface

// ----- rtl/core/srm_store.sv -----
module srm_store #(
	parameter int MAX_LEN = srm_pkg::MAX_LEN_DEF,
	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
	input  logic                       clk,
	input  srm_pkg::wr_t               wr,
	input  logic [AW-1:0]              waddr,
	input  logic [AW-1:0]              src_raddr,
	input  logic [AW-1:0]              dst_raddr,
	output logic [srm_pkg::CHAR_W-1:0] src_rdata,
	output logic [srm_pkg::CHAR_W-1:0] dst_rdata
);

	logic [srm_pkg::CHAR_W-1:0] src_mem [MAX_LEN];
	logic [srm_pkg::CHAR_W-1:0] dst_mem [MAX_LEN];
	logic [srm_pkg::CHAR_W-1:0] src_rdata_q;
	logic [srm_pkg::CHAR_W-1:0] dst_rdata_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			src_mem[waddr] <= wr.src_char;
		end
		src_rdata_q <= src_mem[src_raddr];
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			dst_mem[waddr] <= wr.dst_char;
		end
		dst_rdata_q <= dst_mem[dst_raddr];
	end

	assign src_rdata = src_rdata_q;
	assign dst_rdata = dst_rdata_q;

endmodule

// ----- rtl/core/srm_seq.sv -----
`include "string_rotation_match_macros.svh"

module srm_seq #(
	parameter int MAX_LEN = srm_pkg::MAX_LEN_DEF,
	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1,
	localparam int CW = $clog2(MAX_LEN + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// character pairs
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [srm_pkg::CHAR_W-1:0] src_char,
	input  logic [srm_pkg::CHAR_W-1:0] dst_char,
	input  logic                       last,
	// store ports
	output srm_pkg::wr_t               wr,
	output logic [AW-1:0]              waddr,
	output logic [AW-1:0]              src_raddr,
	output logic [AW-1:0]              dst_raddr,
	input  logic [srm_pkg::CHAR_W-1:0] src_rdata,
	input  logic [srm_pkg::CHAR_W-1:0] dst_rdata,
	// result
	output srm_pkg::res_t              res,
	input  logic                       res_ready
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_CMP  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_LEN);
	localparam logic [CW-1:0] CNT_ONE = CW'(1);

	logic [1:0]                  state_q;
	logic [CW-1:0]               load_cnt_q;
	logic                        ovf_q;
	logic [CW-1:0]               n_q;
	logic [AW-1:0]               r_q;
	logic [AW-1:0]               i_q;
	logic [AW-1:0]               k_q;
	logic [srm_pkg::ROT_W-1:0]   rot_q;
	logic [srm_pkg::STAT_W-1:0]  stat_q;

	logic acc;
	logic full;
	logic i_end;
	logic k_end;
	logic r_end;

	assign in_ready = (state_q == ST_IDLE);
	assign acc      = in_valid && in_ready;
	assign full     = (load_cnt_q >= CNT_MAX);

	assign i_end = ((CW'(i_q) + CNT_ONE) == n_q);
	assign k_end = ((CW'(k_q) + CNT_ONE) == n_q);
	assign r_end = ((CW'(r_q) + CNT_ONE) == n_q);

	assign wr.en       = acc && !full;
	assign wr.src_char = src_char;
	assign wr.dst_char = dst_char;
	assign waddr       = load_cnt_q[AW-1:0];

	// rotated source index against straight target index
	assign src_raddr = k_q;
	assign dst_raddr = i_q;

	assign res.valid     = (state_q == ST_FIN);
	assign res.rotations = rot_q;
	assign res.status    = stat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			load_cnt_q <= '0;
			ovf_q      <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						if (last) begin
							load_cnt_q <= '0;
							ovf_q      <= 1'b0;
							if (ovf_q || full) begin
								state_q <= ST_FIN;
							end else begin
								state_q <= ST_READ;
							end
						end else if (full) begin
							ovf_q <= 1'b1;
						end else begin
							load_cnt_q <= load_cnt_q + CNT_ONE;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (src_rdata == dst_rdata) begin
						state_q <= i_end ? ST_FIN : ST_READ;
					end else begin
						state_q <= r_end ? ST_FIN : ST_READ;
					end
				end
				ST_FIN: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// search counters and result, no reset needed
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (acc && last) begin
					n_q    <= load_cnt_q + CNT_ONE;
					r_q    <= '0;
					i_q    <= '0;
					k_q    <= '0;
					rot_q  <= '0;
					stat_q <= srm_pkg::STAT_OVERFLOW;
				end
			end
			ST_CMP: begin
				if (src_rdata == dst_rdata) begin
					if (i_end) begin
						rot_q  <= srm_pkg::ROT_W'(r_q);
						stat_q <= srm_pkg::STAT_OK;
					end else begin
						i_q <= i_q + AW'(1);
						k_q <= k_end ? '0 : k_q + AW'(1);
					end
				end else if (r_end) begin
					rot_q  <= '0;
					stat_q <= srm_pkg::STAT_NO_MATCH;
				end else begin
					r_q <= r_q + AW'(1);
					i_q <= '0;
					k_q <= r_q + AW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	`SRM_ASSERT_IMP(a_len_nonzero, clk, arst_n, (state_q == ST_READ), (n_q != '0),
		"search started on an empty string")
	`SRM_ASSERT_IMP(a_rot_in_range, clk, arst_n, (state_q == ST_CMP),
		((CW'(r_q) < n_q) && (CW'(i_q) < n_q) && (CW'(k_q) < n_q)),
		"search index beyond loaded length")
	`SRM_ASSERT_NEXT(a_load_cleared, clk, arst_n, (acc && last),
		((load_cnt_q == '0) && !ovf_q), "load state not cleared after last word")
	`SRM_ASSERT_IMP(a_no_write_busy, clk, arst_n, (state_q != ST_IDLE), !wr.en,
		"store written during search")

endmodule

// ----- rtl/core/string_rotation_match.sv -----
// channel  | dir | payload                         | handshake
// chars    | in  | src_char[8] dst_char[8] last[1] | valid/ready
// result   | out | rotations[7] status[2]          | valid/ready
//
// a word without last is stored, or dropped once the store is full, and gives no result
// a last word starts the rotation search unless the string overflowed the store:
//   each character compare is a registered read of both character memories, then
//   the shared comparator
// reset is asynchronous; the character memories are not cleared
// chars.ready is high whenever the sequencer is idle, also while a result
//   waits in the output register; result stalls hold the search only at its end

`include "string_rotation_match_macros.svh"

module string_rotation_match #(
	parameter int MAX_LEN = srm_pkg::MAX_LEN_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	srm_char_if.sink      chars,
	srm_res_if.source     result
);

	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

	// store write and read ports
	srm_pkg::wr_t               wr;
	logic [AW-1:0]              waddr;
	logic [AW-1:0]              src_raddr;
	logic [AW-1:0]              dst_raddr;
	logic [srm_pkg::CHAR_W-1:0] src_rdata;
	logic [srm_pkg::CHAR_W-1:0] dst_rdata;

	// finished result from the sequencer
	srm_pkg::res_t res;
	logic          res_ready;

	// output register
	logic                       out_valid_q;
	logic [srm_pkg::ROT_W-1:0]  out_rot_q;
	logic [srm_pkg::STAT_W-1:0] out_stat_q;

	srm_store #(
		.MAX_LEN (MAX_LEN)
	) u_store (
		.clk       (clk),
		.wr        (wr),
		.waddr     (waddr),
		.src_raddr (src_raddr),
		.dst_raddr (dst_raddr),
		.src_rdata (src_rdata),
		.dst_rdata (dst_rdata)
	);

	srm_seq #(
		.MAX_LEN (MAX_LEN)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (chars.valid),
		.in_ready  (chars.ready),
		.src_char  (chars.src_char),
		.dst_char  (chars.dst_char),
		.last      (chars.last),
		.wr        (wr),
		.waddr     (waddr),
		.src_raddr (src_raddr),
		.dst_raddr (dst_raddr),
		.src_rdata (src_rdata),
		.dst_rdata (dst_rdata),
		.res       (res),
		.res_ready (res_ready)
	);

	// result register takes a new word when empty or being drained
	assign res_ready = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid && res_ready) begin
			out_rot_q  <= res.rotations;
			out_stat_q <= res.status;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.rotations = out_rot_q;
	assign result.status    = out_stat_q;

	// a converted result always names a rotation, other statuses carry zero
	`SRM_ASSERT_IMP(a_rot_zero, clk, arst_n,
		(out_valid_q && (out_stat_q != srm_pkg::STAT_OK)), (out_rot_q == '0),
		"rotation count set on a failed result")
	// the search never answers with a status code outside the defined set
	`SRM_ASSERT_IMP(a_stat_known, clk, arst_n, out_valid_q,
		((out_stat_q == srm_pkg::STAT_OK) || (out_stat_q == srm_pkg::STAT_NO_MATCH) ||
		(out_stat_q == srm_pkg::STAT_OVERFLOW)), "undefined status code")
	// a result leaves the sequencer only into an output register that is empty or being drained
	`SRM_ASSERT_NEXT(a_res_moved, clk, arst_n, (res.valid && res_ready),
		(out_valid_q && !res.valid), "result lost between sequencer and output")

endmodule

// ----- test/tb_string_rotation_match.sv -----
module tb_string_rotation_match;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_LEN = srm_pkg::MAX_LEN_DEF;
	localparam int CHAR_W  = srm_pkg::CHAR_W;
	localparam int ROT_W   = srm_pkg::ROT_W;
	localparam int STAT_W  = srm_pkg::STAT_W;

	localparam logic [STAT_W-1:0] STAT_OK       = srm_pkg::STAT_OK;
	localparam logic [STAT_W-1:0] STAT_NO_MATCH = srm_pkg::STAT_NO_MATCH;
	localparam logic [STAT_W-1:0] STAT_OVERFLOW = srm_pkg::STAT_OVERFLOW;

	// slowest correct run: one full-length search, the random strings of up to
	// 40 characters, 81 percent stalls on either side and one long receiver
	// hold; that stays well inside CYCLE_LIMIT
	localparam int CYCLE_LIMIT = 4_000_000;
	localparam int RESULT_HOLD = 600;
	localparam int DRAIN_CYCLES = 50;
	localparam int MAX_GAP = 40;

	// running count of random words at which each idling phase ends
	localparam int PHASE_A_END = 350;
	localparam int PHASE_B_END = 700;
	localparam int RANDOM_WORDS = 1050;

	// one answer of the block
	typedef struct packed {
		logic [ROT_W-1:0]  rotations;
		logic [STAT_W-1:0] status;
	} verdict_t;

	// one row of the directed table; typed rows carry their answer
	typedef struct packed {
		logic [CHAR_W-1:0] src;
		logic [CHAR_W-1:0] dst;
		logic              last;
		logic              typed;
		logic [ROT_W-1:0]  rot;
		logic [STAT_W-1:0] stat;
	} directed_row_t;

	typedef enum int {
		STR_ROTATED,
		STR_BROKEN,
		STR_UNRELATED,
		STR_COUNTING
	} str_kind_t;

	// single characters first, straight after reset, then short strings
	localparam int DIRECTED_ROWS = 22;
	localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
		// one character that matches itself
		'{8'h61, 8'h61, 1'b1, 1'b1, 7'd0, STAT_OK},
		// extremes of the character range, with and without a match
		'{8'h00, 8'hFF, 1'b1, 1'b1, 7'd0, STAT_NO_MATCH},
		'{8'hFF, 8'hFF, 1'b1, 1'b1, 7'd0, STAT_OK},
		// zero byte is just a character
		'{8'h00, 8'h00, 1'b1, 1'b1, 7'd0, STAT_OK},
		// abc against bca
		'{8'h61, 8'h62, 1'b0, 1'b0, 7'd0, STAT_OK},
		'{8'h62, 8'h63, 1'b0, 1'b0, 7'd0, STAT_OK},
		'{8'h63, 8'h61, 1'b1, 1'b0, 7'd0, STAT_OK},
		// periodic abab against baba, smallest rotation wins
		'{8'h61, 8'h62, 1'b0, 1'b0, 7'd0, STAT_OK},
		'{8'h62, 8'h61, 1'b0, 1'b0, 7'd0, STAT_OK},
		'{8'h61, 8'h62, 1'b0, 1'b0, 7'd0, STAT_OK},
		'{8'h62, 8'h61, 1'b1, 1'b0, 7'd0, STAT_OK},
		// zero bytes around one letter
		'{8'h00, 8'h00, 1'b0, 1'b0, 7'd0, STAT_OK},
		'{8'h41, 8'h00, 1'b0, 1'b0, 7'd0, STAT_OK},
		'{8'h00, 8'h41, 1'b1, 1'b0, 7'd0, STAT_OK},
		// same letters, no rotation fits
		'{8'h78, 8'h78, 1'b0, 1'b0, 7'd0, STAT_OK},
		'{8'h79, 8'h7A, 1'b0, 1'b0, 7'd0, STAT_OK},
		'{8'h7A, 8'h79, 1'b1, 1'b0, 7'd0, STAT_OK},
		// two characters swapped
		'{8'h70, 8'h71, 1'b0, 1'b0, 7'd0, STAT_OK},
		'{8'h71, 8'h70, 1'b1, 1'b0, 7'd0, STAT_OK},
		// all characters equal
		'{8'h6B, 8'h6B, 1'b0, 1'b0, 7'd0, STAT_OK},
		'{8'h6B, 8'h6B, 1'b0, 1'b0, 7'd0, STAT_OK},
		'{8'h6B, 8'h6B, 1'b1, 1'b0, 7'd0, STAT_OK}
	};

	logic clk;
	logic arst_n;

	srm_char_if chars();
	srm_res_if  result();

	string_rotation_match i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars),
		.result (result)
	);

	// predictor copy of the character stores
	logic [CHAR_W-1:0] src_mem [MAX_LEN];
	logic [CHAR_W-1:0] dst_mem [MAX_LEN];
	int                held_pairs;
	bit                pairs_dropped;

	// answers waiting for the result channel, oldest first
	verdict_t expected_verdicts[$];

	// idling percentages, set by the stimulus, read by both drivers
	int snd_idle_pct;
	int rcv_idle_pct;
	bit hold_req;

	int errors;
	int cycle_count;
	int words_sent;
	int random_words;
	int strings_sent;
	int results_checked;
	int no_match_seen;
	int overflow_seen;
	int deepest_rotation;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// does source rotated left by r equal target over the held pairs
	function automatic bit rotation_fits(input int r);
		int k;
		for (int i = 0; i < held_pairs; i++) begin
			k = i + r;
			if (k >= held_pairs)
				k -= held_pairs;
			if (src_mem[k] != dst_mem[i])
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// store one pair; on the last word work out the answer and clear the load
	function automatic bit search_rotation(input logic [CHAR_W-1:0] src,
			input logic [CHAR_W-1:0] dst, input logic last, output verdict_t verdict);
		bit found;
		verdict = '{rotations: '0, status: STAT_NO_MATCH};
		found = 1'b0;
		if (held_pairs < MAX_LEN) begin
			src_mem[held_pairs] = src;
			dst_mem[held_pairs] = dst;
			held_pairs++;
		end else begin
			pairs_dropped = 1'b1;
		end
		if (!last)
			return 1'b0;
		if (pairs_dropped) begin
			verdict.status = STAT_OVERFLOW;
		end else begin
			for (int r = 0; r < held_pairs && !found; r++) begin
				if (rotation_fits(r)) begin
					verdict.rotations = ROT_W'(r);
					verdict.status = STAT_OK;
					found = 1'b1;
				end
			end
		end
		held_pairs = 0;
		pairs_dropped = 1'b0;
		return 1'b1;
	endfunction

	// offer one word after a random gap and wait until it is taken
	task automatic send_word(input logic [CHAR_W-1:0] src, input logic [CHAR_W-1:0] dst,
			input logic last, input logic typed = 1'b0, input verdict_t typed_verdict = '0);
		int gap;
		verdict_t verdict;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < snd_idle_pct)
			gap++;
		if (gap > 0) begin
			chars.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		chars.valid    <= 1'b1;
		chars.src_char <= src;
		chars.dst_char <= dst;
		chars.last     <= last;
		do
			@(posedge clk);
		while (!chars.ready);
		words_sent++;
		if (search_rotation(src, dst, last, verdict))
			expected_verdicts.push_back(typed ? typed_verdict : verdict);
	endtask

	// build a source string and a target derived from it, then send the pairs
	task automatic send_string(input int len, input str_kind_t kind);
		logic [CHAR_W-1:0] src[$];
		logic [CHAR_W-1:0] dst[$];
		logic [CHAR_W-1:0] sym_a;
		logic [CHAR_W-1:0] sym_b;
		int style;
		int period;
		int rot;
		int pos;
		sym_a = CHAR_W'($urandom_range(255));
		sym_b = CHAR_W'($urandom_range(255));
		style = $urandom_range(2);
		period = $urandom_range(3, 1);
		for (int i = 0; i < len; i++) begin
			if (kind == STR_COUNTING)
				src.push_back(CHAR_W'(i));
			else if (style == 0)
				src.push_back(CHAR_W'($urandom_range(255)));
			else if (style == 1)
				src.push_back($urandom_range(1) ? sym_a : sym_b);
			else
				src.push_back((i % period == 0) ? sym_a : sym_b);
		end
		// counting string rotated by len-1 has one fitting rotation, the largest
		if (kind == STR_COUNTING)
			rot = len - 1;
		else
			rot = (len > 1) ? $urandom_range(len - 1) : 0;
		for (int i = 0; i < len; i++) begin
			if (kind == STR_UNRELATED)
				dst.push_back(src[$urandom_range(len - 1)]);
			else
				dst.push_back(src[(i + rot) % len]);
		end
		if (kind == STR_BROKEN) begin
			pos = $urandom_range(len - 1);
			dst[pos] = dst[pos] ^ CHAR_W'(1 << $urandom_range(CHAR_W - 1));
		end
		for (int i = 0; i < len; i++)
			send_word(src[i], dst[i], i == len - 1);
		random_words += len;
		strings_sent++;
	endtask

	// mostly short strings, now and then long ones and overlong ones
	task automatic send_random_string();
		int pick;
		int len;
		str_kind_t kind;
		pick = $urandom_range(99);
		if (pick < 60)
			len = $urandom_range(6, 1);
		else if (pick < 90)
			len = $urandom_range(16, 7);
		else if (pick < 99)
			len = $urandom_range(40, 17);
		else
			len = $urandom_range(MAX_LEN + 2, MAX_LEN + 1);
		pick = $urandom_range(99);
		if (pick < 65)
			kind = STR_ROTATED;
		else if (pick < 85)
			kind = STR_BROKEN;
		else if (pick < 95)
			kind = STR_UNRELATED;
		else
			kind = STR_COUNTING;
		send_string(len, kind);
	endtask

	// withdraw the offer and hold back until the block has handed over every answer
	task automatic wait_drained();
		chars.valid <= 1'b0;
		do
			@(posedge clk);
		while (expected_verdicts.size() != 0);
	endtask

	// stimulus
	initial begin
		arst_n         <= 1'b0;
		chars.valid    <= 1'b0;
		chars.src_char <= '0;
		chars.dst_char <= '0;
		chars.last     <= 1'b0;
		held_pairs     = 0;
		pairs_dropped  = 1'b0;
		hold_req       = 1'b0;
		snd_idle_pct   = 6;
		rcv_idle_pct   = 81;
		words_sent     = 0;
		random_words   = 0;
		strings_sent   = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed table, sender idles rarely, receiver often
		for (int row = 0; row < DIRECTED_ROWS; row++) begin
			send_word(DIRECTED[row].src, DIRECTED[row].dst, DIRECTED[row].last,
				DIRECTED[row].typed, '{rotations: DIRECTED[row].rot, status: DIRECTED[row].stat});
			if (DIRECTED[row].last)
				strings_sent++;
		end

		// full-length string needing the largest rotation
		wait_drained();
		send_string(MAX_LEN, STR_COUNTING);
		while (random_words < PHASE_A_END)
			send_random_string();

		// sender idles often, receiver rarely; one pair past the store size
		wait_drained();
		snd_idle_pct = 81;
		rcv_idle_pct = 6;
		send_string(MAX_LEN + 1, STR_ROTATED);
		while (random_words < PHASE_B_END)
			send_random_string();

		// nobody idles; an overlong string, then a long receiver hold that
		// backs results up into the block while words keep coming
		wait_drained();
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		send_string(MAX_LEN + 3, STR_BROKEN);
		hold_req = 1'b1;
		while (random_words < RANDOM_WORDS)
			send_random_string();

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d words in %0d strings, %0d results checked",
			words_sent, strings_sent, results_checked);
		$display("%0d without a match, %0d too long, deepest rotation %0d",
			no_match_seen, overflow_seen, deepest_rotation);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// result receiver: random stalls, plus one long hold counted here
	initial begin
		int held_cycles;
		result.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				result.ready <= 1'b0;
				held_cycles = 0;
				while (held_cycles < RESULT_HOLD) begin
					@(posedge clk);
					held_cycles++;
				end
			end
			result.ready <= ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	// compare each taken result with the oldest outstanding answer
	initial begin
		errors = 0;
		results_checked = 0;
		no_match_seen = 0;
		overflow_seen = 0;
		deepest_rotation = 0;
	end

	always @(posedge clk) begin
		verdict_t want;
		if (result.valid && result.ready) begin
			if (expected_verdicts.size() == 0) begin
				$error("result with nothing outstanding: rotations %0d status %0d",
					result.rotations, result.status);
				errors++;
			end else begin
				want = expected_verdicts.pop_front();
				results_checked++;
				if (result.rotations !== want.rotations) begin
					$error("rotations mismatch: expected %0d, got %0d",
						want.rotations, result.rotations);
					errors++;
				end
				if (result.status !== want.status) begin
					$error("status mismatch: expected %0d, got %0d", want.status, result.status);
					errors++;
				end
				if (want.status == STAT_NO_MATCH)
					no_match_seen++;
				if (want.status == STAT_OVERFLOW)
					overflow_seen++;
				if (want.status == STAT_OK && int'(want.rotations) > deepest_rotation)
					deepest_rotation = int'(want.rotations);
			end
		end
	end

	// watchdog
	initial cycle_count = 0;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

endmodule

// ----- string_rotation_match.f -----
+incdir+rtl/core
rtl/core/srm_pkg.sv
rtl/core/srm_channels.sv
rtl/core/srm_store.sv
rtl/core/srm_seq.sv
rtl/core/string_rotation_match.sv
test/tb_string_rotation_match.sv
